/* design/delimited_decimal_field_parser_macros.svh */
// Assertion macros used by the checker file.
`ifndef DELIMITED_DECIMAL_FIELD_PARSER_MACROS_SVH
`define DELIMITED_DECIMAL_FIELD_PARSER_MACROS_SVH

// same-cycle implication
`define DDFP_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication
`define DDFP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

/* design/ddfp_pkg.sv */
package ddfp_pkg;

    localparam int FIELD_INDEX_W = 5;
    localparam int SCALE_W       = 24;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_INT,
        PH_FRAC,
        PH_DEAD
    } ddfp_phase_t;

    typedef struct packed {
        logic                     saturated;
        logic [FIELD_INDEX_W-1:0] field_index;
    } ddfp_tag_t;

    // 10^n for n up to 6
    function automatic logic [SCALE_W-1:0] pow10(input logic [2:0] n);
        logic [SCALE_W-1:0] r;
        case (n)
            3'd0:    r = SCALE_W'(1);
            3'd1:    r = SCALE_W'(10);
            3'd2:    r = SCALE_W'(100);
            3'd3:    r = SCALE_W'(1000);
            3'd4:    r = SCALE_W'(10000);
            3'd5:    r = SCALE_W'(100000);
            default: r = SCALE_W'(1000000);
        endcase
        return r;
    endfunction

endpackage

/* design/ddfp_parser.sv */
module ddfp_parser
    import ddfp_pkg::*;
#(
    parameter int FRAC_DIGITS = 3,
    parameter int MAX_FIELDS  = 20,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             char_byte,
    input  logic                   end_of_line,
    input  logic                   skip_first_token,
    output logic                   emit,
    output logic [VALUE_WIDTH-1:0] value,
    output ddfp_tag_t              tag
);

    localparam int MW = VALUE_WIDTH - 1;
    localparam int EW = (VALUE_WIDTH + 4 > 26) ? VALUE_WIDTH + 4 : 26;
    localparam int CW = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
    localparam int TW = $clog2(MAX_FIELDS + 2);
    localparam int IW = (TW > FIELD_INDEX_W) ? TW : FIELD_INDEX_W;
    localparam logic [EW-1:0] VMAX_EXT = EW'({MW{1'b1}});

    ddfp_phase_t   phase_reg, phase_next;
    logic          neg_reg, neg_next;
    logic [MW-1:0] mag_reg, mag_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [TW-1:0] tcount_reg, tcount_next;

    logic          is_sep, is_digit, is_minus, is_point;
    logic [3:0]    digit;
    logic [2:0]    fexp;
    logic [EW-1:0] mag_ext, int_sum, frac_sum, pushed;
    logic          push;
    logic          closing;
    logic [TW-1:0] idx;
    logic [IW-1:0] idx_ext;
    logic [VALUE_WIDTH-1:0] mag_full;

    assign is_sep   = (char_byte == CH_SPACE) || (char_byte == CH_TAB) ||
                      (char_byte == CH_CR) || (char_byte == CH_LF);
    assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    assign is_minus = (char_byte == CH_MINUS);
    assign is_point = (char_byte == CH_POINT);
    assign digit    = char_byte[3:0];
    // weight of the next fraction digit: 10^(FRAC_DIGITS-1-count)
    assign fexp     = 3'(FRAC_DIGITS - 1 - int'(cnt_reg));

    // the accumulator holds the value already scaled by 10^FRAC_DIGITS
    assign mag_ext  = EW'(mag_reg);
    assign int_sum  = (mag_ext << 3) + (mag_ext << 1) +
                      EW'(digit) * EW'(pow10(3'(FRAC_DIGITS)));
    assign frac_sum = mag_ext + EW'(digit) * EW'(pow10(fexp));

    assign closing  = step && (end_of_line || is_sep) && (phase_reg != PH_IDLE);

    always_comb
    begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        tcount_next = tcount_reg;
        push        = 1'b0;
        pushed      = int_sum;

        if (step) begin
            if (end_of_line || is_sep) begin
                if (phase_reg != PH_IDLE) begin
                    phase_next = PH_IDLE;
                    neg_next   = 1'b0;
                    mag_next   = '0;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    if (tcount_reg < TW'(MAX_FIELDS + 1)) begin
                        tcount_next = tcount_reg + 1'b1;
                    end
                end
                if (end_of_line) begin
                    tcount_next = '0;
                end
            end else begin
                unique case (phase_reg)
                    PH_IDLE, PH_INT:
                    begin
                        phase_next = PH_INT;
                        if (phase_reg == PH_IDLE && is_minus) begin
                            neg_next = 1'b1;
                        end else if (is_digit) begin
                            push = 1'b1;
                        end else if (is_point) begin
                            phase_next = PH_FRAC;
                        end else begin
                            phase_next = PH_DEAD;
                        end
                    end
                    PH_FRAC:
                    begin
                        if (is_digit) begin
                            if (cnt_reg < CW'(FRAC_DIGITS)) begin
                                push     = 1'b1;
                                pushed   = frac_sum;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end else begin
                            phase_next = PH_DEAD;
                        end
                    end
                    PH_DEAD:
                    begin
                        phase_next = PH_DEAD;
                    end
                    default:
                    begin
                        phase_next = PH_DEAD;
                    end
                endcase
                if (push) begin
                    if (pushed > VMAX_EXT) begin
                        mag_next = {MW{1'b1}};
                        ovf_next = 1'b1;
                    end else begin
                        mag_next = MW'(pushed);
                    end
                end
            end
        end
    end

    // result of the token that closes in this cycle
    always_comb
    begin
        idx      = tcount_reg - TW'(skip_first_token);
        idx_ext  = IW'(idx);
        mag_full = VALUE_WIDTH'(mag_reg);
        emit     = closing && !(skip_first_token && tcount_reg == '0) &&
                   (idx < TW'(MAX_FIELDS));
        value    = neg_reg ? (-mag_full) : mag_full;
        tag.saturated   = ovf_reg;
        tag.field_index = idx_ext[FIELD_INDEX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_IDLE;
            neg_reg    <= 1'b0;
            mag_reg    <= '0;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            tcount_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            mag_reg    <= mag_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            tcount_reg <= tcount_next;
        end
    end

endmodule

/* design/delimited_decimal_field_parser.sv */
// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------
// in       in_valid / in_ready  char_byte, end_of_line
// out      out_valid/out_ready  value, saturated, field_index
// cfg      cfg_wr_en            cfg_wr_data (skip_first_token)
//
// One item per cycle while in_ready is high: the parse state and, for a
// closing token, the output register (or skid) load at the accepting
// edge, so out_valid is high the cycle after the closing delimiter or
// end_of_line is accepted. Output has a two-entry buffer (output register
// plus skid), so in_ready drops only when both entries hold results.
// Reset (async, rst_n low) clears parse state and both buffer entries and
// sets skip_first_token to 1.
module delimited_decimal_field_parser
    import ddfp_pkg::*;
#(
    parameter int FRAC_DIGITS = 3,
    parameter int MAX_FIELDS  = 20,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    char_byte,
    input  logic                          end_of_line,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0] value,
    output logic                          saturated,
    output logic [FIELD_INDEX_W-1:0]      field_index,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data
);

    logic                   skip_reg;
    logic                   accept;
    logic                   emit;
    logic [VALUE_WIDTH-1:0] res_value;
    ddfp_tag_t              res_tag;

    logic                   main_valid_reg, main_valid_next;
    logic [VALUE_WIDTH-1:0] main_value_reg, main_value_next;
    ddfp_tag_t              main_tag_reg, main_tag_next;
    logic                   skid_valid_reg, skid_valid_next;
    logic [VALUE_WIDTH-1:0] skid_value_reg, skid_value_next;
    ddfp_tag_t              skid_tag_reg, skid_tag_next;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;

    ddfp_parser #(
        .FRAC_DIGITS (FRAC_DIGITS),
        .MAX_FIELDS  (MAX_FIELDS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (accept),
        .char_byte        (char_byte),
        .end_of_line      (end_of_line),
        .skip_first_token (skip_reg),
        .emit             (emit),
        .value            (res_value),
        .tag              (res_tag)
    );

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_value_next = main_value_reg;
        main_tag_next   = main_tag_reg;
        skid_valid_next = skid_valid_reg;
        skid_value_next = skid_value_reg;
        skid_tag_next   = skid_tag_reg;

        if (skid_valid_reg) begin
            // no item accepted here, so only drain
            if (out_ready) begin
                main_value_next = skid_value_reg;
                main_tag_next   = skid_tag_reg;
                skid_valid_next = 1'b0;
            end
        end else if (emit) begin
            if (!main_valid_reg || out_ready) begin
                main_valid_next = 1'b1;
                main_value_next = res_value;
                main_tag_next   = res_tag;
            end else begin
                skid_valid_next = 1'b1;
                skid_value_next = res_value;
                skid_tag_next   = res_tag;
            end
        end else if (out_ready) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            skip_reg       <= 1'b1;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                skip_reg <= cfg_wr_data;
            end
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_value_reg <= main_value_next;
        main_tag_reg   <= main_tag_next;
        skid_value_reg <= skid_value_next;
        skid_tag_reg   <= skid_tag_next;
    end

    assign out_valid   = main_valid_reg;
    assign value       = main_value_reg;
    assign saturated   = main_tag_reg.saturated;
    assign field_index = main_tag_reg.field_index;

endmodule

/* design/ddfp_checker.sv */
`include "delimited_decimal_field_parser_macros.svh"

module ddfp_checker
    import ddfp_pkg::*;
#(
    parameter int MAX_FIELDS  = 20,
    parameter int VALUE_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [VALUE_WIDTH-1:0] value,
    input logic                          saturated,
    input logic [FIELD_INDEX_W-1:0]      field_index
);

    localparam logic [VALUE_WIDTH-1:0] POS_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] NEG_MAX = -POS_MAX;
    localparam logic [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic                                 out_stall;
    logic [VALUE_WIDTH+FIELD_INDEX_W:0]   out_word;
    logic                                 at_limit;
    logic                                 index_ok;

    assign out_stall = out_valid && !out_ready;
    assign out_word  = {value, saturated, field_index};
    assign at_limit  = (value == POS_MAX) || (value == NEG_MAX);
    assign index_ok  = (MAX_FIELDS > 31) || (field_index < FIELD_INDEX_W'(MAX_FIELDS));

    // stalled result holds
    `DDFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_word))

    // a clamped result is exactly the positive or negative limit
    `DDFP_ASSERT_NOW(a_sat_limit, clk, rst_n, out_valid && saturated, at_limit)

    // magnitude never exceeds the positive limit
    `DDFP_ASSERT_NOW(a_no_most_neg, clk, rst_n, out_valid, value != MOST_NEG)

    `DDFP_ASSERT_NOW(a_index_range, clk, rst_n, out_valid, index_ok)

    // input stalls only while results back up at the output
    `DDFP_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_ready, out_valid)

endmodule

bind delimited_decimal_field_parser ddfp_checker #(
    .MAX_FIELDS  (MAX_FIELDS),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_ddfp_checker (.*);
